### hdl/bf_pkg.sv
// Shared types and constants for the Blowfish block cipher.
package bf_pkg;

   // Feistel round count and P table layout
   localparam int ROUND_COUNT = 16;
   localparam int P_ENTRIES   = 18;
   localparam int BOX_COUNT   = 4;
   localparam int BOX_ENTRIES = 256;

   localparam int P_ADDR_W   = $clog2(P_ENTRIES);
   localparam int BOX_ADDR_W = $clog2(BOX_ENTRIES);
   localparam int ROUND_W    = $clog2(ROUND_COUNT);

   // last P index: hi key on encrypt, first round key on decrypt
   localparam logic [P_ADDR_W-1:0] LAST_KEY = P_ADDR_W'(P_ENTRIES - 1);

   // request codes
   typedef enum logic [1:0] {
      MODE_ENCRYPT = 2'd0,
      MODE_DECRYPT = 2'd1,
      MODE_WRITE_P = 2'd2,
      MODE_WRITE_S = 2'd3
   } mode_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND_READ,
      ST_ROUND_MIX,
      ST_FINISH
   } state_type;

endpackage

### hdl/bf_if.sv
// Request and response channel interfaces of the Blowfish block cipher.
interface bf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] block_in;
   logic [1:0]  box_select;
   logic [7:0]  entry_index;
   logic [31:0] entry_word;

   modport source (output valid, mode, block_in, box_select, entry_index, entry_word,
                   input ready);
   modport sink (input valid, mode, block_in, box_select, entry_index, entry_word,
                 output ready);
endinterface

interface bf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_out;

   modport source (output valid, block_out, input ready);
   modport sink (input valid, block_out, output ready);
endinterface

### hdl/blowfish_block_cipher.sv
// Blowfish block cipher: table loads, encrypt and decrypt over P and S memories.
//
//  channel | dir | beat carries                                       | accepted when
//  req     | in  | mode, block_in, box_select, entry_index, entry_word | valid && ready
//  rsp     | out | block_out (encrypt and decrypt only)               | valid && ready
//
// A table write is stored on the edge its beat is taken.
// An encrypt or decrypt runs from acceptance to a result in the output
// register as one P key load, then 16 rounds of an S-box read and then a
// mix, split by the registered read port of the four S-box banks inside the
// round loop, then a final step for the whitening key.
// req.ready is high only while the sequencer is idle; a result held by rsp
// back-pressure does not block the next request until a second result is due.
// Reset clears control state only; table contents are undefined until written.
module blowfish_block_cipher (
   input  logic      clock,
   input  logic      reset,
   bf_req_if.sink    req,
   bf_rsp_if.source  rsp
);

   localparam int PW = bf_pkg::P_ADDR_W;
   localparam int SW = bf_pkg::BOX_ADDR_W;
   localparam int RW = bf_pkg::ROUND_W;
   localparam int NB = bf_pkg::BOX_COUNT;
   localparam logic [PW-1:0] LAST_KEY_C = bf_pkg::LAST_KEY;

   // tables
   logic [31:0] p_mem [bf_pkg::P_ENTRIES];
   logic [31:0] s_mem [NB][bf_pkg::BOX_ENTRIES];

   bf_pkg::state_type state_ff, state_in;

   logic [RW-1:0] round_ff, round_in;
   logic          decrypt_ff, decrypt_in;
   logic [31:0]   y_ff, y_in;
   logic [31:0]   z_ff, z_in;
   logic [63:0]   block_out_ff, block_out_in;
   logic          out_valid_ff, out_valid_in;

   logic [31:0]           p_rdata_ff;
   logic [NB-1:0][31:0]   s_rdata_ff;
   logic [NB-1:0][SW-1:0] s_raddr;
   logic [PW-1:0]         p_raddr;
   logic [PW-1:0]         key_pos;
   logic                  key_dec;

   logic        accept;
   logic        is_cipher;
   logic        p_we;
   logic        s_we;
   logic        last_round;
   logic        out_free;
   logic [31:0] feistel;

   assign accept     = req.valid && req.ready;
   assign is_cipher  = (req.mode == bf_pkg::MODE_ENCRYPT) || (req.mode == bf_pkg::MODE_DECRYPT);
   assign p_we       = accept && (req.mode == bf_pkg::MODE_WRITE_P)
                       && (req.entry_index < 8'(bf_pkg::P_ENTRIES));
   assign s_we       = accept && (req.mode == bf_pkg::MODE_WRITE_S);
   assign last_round = (round_ff == RW'(bf_pkg::ROUND_COUNT - 1));
   assign out_free   = !out_valid_ff || rsp.ready;

   assign req.ready     = (state_ff == bf_pkg::ST_IDLE);
   assign rsp.valid     = out_valid_ff;
   assign rsp.block_out = block_out_ff;

   // P memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (p_we) begin
         p_mem[req.entry_index[PW-1:0]] <= req.entry_word;
      end
      p_rdata_ff <= p_mem[p_raddr];
   end

   // S-box memory, one bank per box, each read at one address a cycle
   always_ff @(posedge clock) begin
      for (int b = 0; b < NB; b++) begin
         if (s_we && (req.box_select == 2'(b))) begin
            s_mem[b][req.entry_index] <= req.entry_word;
         end
         s_rdata_ff[b] <= s_mem[b][s_raddr[b]];
      end
   end

   // S-box addresses: box 0 takes the top byte of z
   always_comb begin
      for (int b = 0; b < NB; b++) begin
         s_raddr[b] = z_ff[31 - 8*b -: 8];
      end
   end

   // round function on the banked read data
   assign feistel = ((s_rdata_ff[0] + s_rdata_ff[1]) ^ s_rdata_ff[2]) + s_rdata_ff[3];

   // P read address: key position, mirrored for decrypt
   assign p_raddr = key_dec ? (LAST_KEY_C - key_pos) : key_pos;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bf_pkg::ST_IDLE: begin
            if (accept && is_cipher) state_in = bf_pkg::ST_LOAD;
         end
         bf_pkg::ST_LOAD:       state_in = bf_pkg::ST_ROUND_READ;
         bf_pkg::ST_ROUND_READ: state_in = bf_pkg::ST_ROUND_MIX;
         bf_pkg::ST_ROUND_MIX: begin
            state_in = last_round ? bf_pkg::ST_FINISH : bf_pkg::ST_ROUND_READ;
         end
         bf_pkg::ST_FINISH: begin
            if (out_free) state_in = bf_pkg::ST_IDLE;
         end
         default: state_in = bf_pkg::ST_IDLE;
      endcase
   end

   // datapath and output control
   always_comb begin
      round_in     = round_ff;
      decrypt_in   = decrypt_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      block_out_in = block_out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      key_pos      = '0;
      key_dec      = decrypt_ff;
      unique case (state_ff)
         bf_pkg::ST_IDLE: begin
            // first round key is read on the accepting edge
            key_dec = (req.mode == bf_pkg::MODE_DECRYPT);
            if (accept) begin
               decrypt_in = key_dec;
               round_in   = '0;
               z_in       = req.block_in[63:32];
               y_in       = req.block_in[31:0];
            end
         end
         bf_pkg::ST_LOAD: begin
            z_in = z_ff ^ p_rdata_ff;
         end
         bf_pkg::ST_ROUND_READ: begin
            // fetch key of the next round (lo whitening key after the last)
            key_pos = PW'(round_ff) + PW'(1);
         end
         bf_pkg::ST_ROUND_MIX: begin
            // fetch hi whitening key; only used after the last round
            key_pos  = LAST_KEY_C;
            y_in     = z_ff;
            z_in     = feistel ^ y_ff ^ p_rdata_ff;
            round_in = round_ff + RW'(1);
         end
         bf_pkg::ST_FINISH: begin
            key_pos = LAST_KEY_C;
            if (out_free) begin
               block_out_in = {y_ff ^ p_rdata_ff, z_ff};
               out_valid_in = 1'b1;
            end
         end
         default: begin
            key_pos = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         round_ff     <= '0;
         decrypt_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         round_ff     <= round_in;
         decrypt_ff   <= decrypt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      z_ff         <= z_in;
      block_out_ff <= block_out_in;
   end

endmodule

### hdl/bf_checker.sv
// Port-level checker for the Blowfish block cipher, bound to the top level.
module bf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_block_out
);

   logic req_beat;
   logic cipher_beat;

   assign req_beat    = req_valid && req_ready;
   assign cipher_beat = req_beat && ((req_mode == bf_pkg::MODE_ENCRYPT)
                                     || (req_mode == bf_pkg::MODE_DECRYPT));

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a held result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_block_out))
      else $error("rsp payload changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a cipher beat starts the sequencer, so no beat follows at once
   a_busy_after_cipher: assert property (@(posedge clock) disable iff (reset)
      cipher_beat |=> !req_ready)
      else $error("request taken right after a cipher beat");

   // a result never appears just after a request beat
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_beat, 1) && !$past(req_beat, 2))
      else $error("result too soon after a request beat");

endmodule

bind blowfish_block_cipher bf_checker u_bf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_mode      (req.mode),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_block_out (rsp.block_out)
);
